[rtl/core/dsad_pkg.sv]
// Shared types, constants and the delta table function for the delta/squelch
// audio decoder. No dependencies.
package dsad_pkg;

  localparam int unsigned CmdDepthDefault = 2;
  localparam logic [7:0]  BlockSizeReset  = 8'd16;

  // What the back end must do with a queued command
  typedef enum logic [1:0] {
    CMD_RAW     = 2'd0,
    CMD_RESYNC  = 2'd1,
    CMD_SQUELCH = 2'd2,
    CMD_DELTA   = 2'd3
  } cmd_kind_e;

  // Code width as carried in the header field: 1, 2, or 3 meaning 4 bits
  localparam logic [1:0] WCODE_1 = 2'd1;
  localparam logic [1:0] WCODE_2 = 2'd2;
  localparam logic [1:0] WCODE_4 = 2'd3;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;   // raw byte, resync byte or packed delta codes
    logic [5:0] count;  // samples this command yields
    logic [1:0] wcode;
    logic [3:0] mult;
  } cmd_t;

  // delta = -(8-pos)*(m+1) below the center, (pos-7)*(m+1) above it;
  // top entry of the largest multiplier saturates to 127
  function automatic logic signed [8:0] dsad_delta(input logic [3:0] mult,
                                                   input logic [3:0] pos);
    logic [4:0] m1;
    logic [3:0] steps;
    logic [8:0] mag;
    m1 = {1'b0, mult} + 5'd1;
    if (pos[3]) begin
      steps = {1'b0, pos[2:0]} + 4'd1;
    end else begin
      steps = 4'd8 - {1'b0, pos[2:0]};
    end
    // product reaches 128, so widen both operands first
    mag = {5'd0, steps} * {4'd0, m1};
    if (mult == 4'd15 && pos == 4'd15) begin
      return 9'sd127;
    end else if (pos[3]) begin
      return $signed(mag);
    end else begin
      return -$signed(mag);
    end
  endfunction

endpackage

[rtl/core/dsad_front.sv]
// Front end: accepts coded bytes, tracks block/header state and turns each
// byte that yields samples into a back-end command. Depends on dsad_pkg.
module dsad_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     code_byte_i,
  input  logic           frame_start_i,
  output logic           push_o,
  output dsad_pkg::cmd_t push_cmd_o,
  input  logic           q_full_i
);
  import dsad_pkg::*;

  logic [7:0] block_size_q;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [1:0] wcode_q, wcode_d;
  logic [3:0] mult_q, mult_d;
  logic       accept;
  logic [1:0] hdr_wcode;
  logic [5:0] spb;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hdr_wcode  = code_byte_i[5:4];

  always_comb begin
    case (wcode_q)
      WCODE_1: spb = 6'd8;
      WCODE_2: spb = 6'd4;
      default: spb = 6'd2;
    endcase
  end

  always_comb begin
    bytes_left_d     = bytes_left_q;
    wcode_d          = wcode_q;
    mult_d           = mult_q;
    push_o           = 1'b0;
    push_cmd_o.kind  = CMD_RAW;
    push_cmd_o.data  = code_byte_i;
    push_cmd_o.count = 6'd1;
    push_cmd_o.wcode = wcode_q;
    push_cmd_o.mult  = mult_q;
    if (accept) begin
      if (frame_start_i) begin
        bytes_left_d = '0;
        push_o       = 1'b1;
      end else if (bytes_left_q != '0) begin
        bytes_left_d     = bytes_left_q - 8'd1;
        push_o           = 1'b1;
        push_cmd_o.kind  = CMD_DELTA;
        push_cmd_o.count = spb;
      end else if (code_byte_i[7]) begin
        push_o          = 1'b1;
        push_cmd_o.kind = CMD_RESYNC;
      end else if (code_byte_i[6]) begin
        // squelch of zero yields nothing, so nothing is queued
        push_o           = (code_byte_i[5:0] != '0);
        push_cmd_o.kind  = CMD_SQUELCH;
        push_cmd_o.count = code_byte_i[5:0];
      end else if (hdr_wcode != 2'd0) begin
        wcode_d = hdr_wcode;
        mult_d  = code_byte_i[3:0];
        case (hdr_wcode)
          WCODE_1: bytes_left_d = {3'd0, block_size_q[7:3]};
          WCODE_2: bytes_left_d = {2'd0, block_size_q[7:2]};
          default: bytes_left_d = {1'b0, block_size_q[7:1]};
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeReset;
      bytes_left_q <= '0;
      wcode_q      <= WCODE_1;
      mult_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        block_size_q <= cfg_wdata_i;
      end
      bytes_left_q <= bytes_left_d;
      wcode_q      <= wcode_d;
      mult_q       <= mult_d;
    end
  end

endmodule

[rtl/core/dsad_cmd_fifo.sv]
// Short command queue between front and back end.
// Depends on dsad_pkg.
module dsad_cmd_fifo #(
  parameter int unsigned Depth = dsad_pkg::CmdDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dsad_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output dsad_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import dsad_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/dsad_back.sv]
// Back end: executes queued commands, one sample per cycle into the output
// register when not stalled, owning the previous-sample state. Depends on dsad_pkg.
module dsad_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dsad_pkg::cmd_t head_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     sample_o,
  output logic           last_o
);
  import dsad_pkg::*;

  logic              busy_q;
  cmd_kind_e         kind_q;
  logic [7:0]        sh_q;
  logic [5:0]        cnt_q;
  logic [1:0]        wcode_q;
  logic [3:0]        mult_q;
  logic [7:0]        prev_q;
  logic              ovalid_q;
  logic [7:0]        osample_q;
  logic              olast_q;

  logic              fire;
  logic [3:0]        code, pos;
  logic [7:0]        sh_next;
  logic signed [8:0] delta;
  logic signed [9:0] sum;
  logic [7:0]        delta_sample, next_sample;

  assign pop_o       = !busy_q && !q_empty_i;
  assign fire        = busy_q && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign sample_o    = osample_q;
  assign last_o      = olast_q;

  // most significant code first; pos centers the code on the table
  always_comb begin
    case (wcode_q)
      WCODE_1: begin
        code    = {3'd0, sh_q[7]};
        pos     = 4'd7 + code;
        sh_next = {sh_q[6:0], 1'b0};
      end
      WCODE_2: begin
        code    = {2'd0, sh_q[7:6]};
        pos     = 4'd6 + code;
        sh_next = {sh_q[5:0], 2'd0};
      end
      default: begin
        code    = sh_q[7:4];
        pos     = code;
        sh_next = {sh_q[3:0], 4'd0};
      end
    endcase
  end

  always_comb begin
    delta = dsad_delta(mult_q, pos);
    sum   = $signed({2'b00, prev_q}) + $signed({delta[8], delta});
    if (sum < 0) begin
      delta_sample = 8'd0;
    end else if (sum > 10'sd255) begin
      delta_sample = 8'd255;
    end else begin
      delta_sample = sum[7:0];
    end
    case (kind_q)
      CMD_RAW:     next_sample = sh_q;
      CMD_RESYNC:  next_sample = {sh_q[6:0], 1'b0};
      CMD_SQUELCH: next_sample = prev_q;
      CMD_DELTA:   next_sample = delta_sample;
      default:     next_sample = prev_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q  <= head_i.kind;
      sh_q    <= head_i.data;
      wcode_q <= head_i.wcode;
      mult_q  <= head_i.mult;
    end else if (fire) begin
      sh_q <= sh_next;
    end
    if (fire) begin
      osample_q <= next_sample;
      olast_q   <= (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      prev_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= head_i.count;
      end else if (fire) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
      if (fire) begin
        prev_q   <= next_sample;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/delta_squelch_audio_decoder_unit.sv]
// Delta/squelch audio decoder: one coded byte in, unsigned 8-bit samples out.
// A front end classifies each byte and queues any command it yields; the back
// end emits one sample per cycle while the output is not stalled, through a
// registered output. Each command is loaded and then emits its samples: a
// delta data byte yields 2, 4 or 8 samples (width 4, 2, 1), a squelch of n
// yields n, and a frame start or resync yields one. Header, ignored and zero
// squelch bytes queue nothing. The back end sets the sustained rate; the
// command queue (CMD_DEPTH entries) lets input continue while a run drains.
// Depends on dsad_pkg, dsad_front, dsad_cmd_fifo and dsad_back.
module delta_squelch_audio_decoder_unit #(
  parameter int unsigned CMD_DEPTH = dsad_pkg::CmdDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,    // block_size
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] code_byte
  input  logic [0:0] s_axis_tuser,   // [0] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] sample
  output logic       m_axis_tlast    // last_of_run
);
  import dsad_pkg::*;

  logic push, pop, q_empty, q_full;
  cmd_t push_cmd, head_cmd;

  dsad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .code_byte_i   (s_axis_tdata),
    .frame_start_i (s_axis_tuser[0]),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .q_full_i      (q_full)
  );

  dsad_cmd_fifo #(
    .Depth (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  dsad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule
